@@ hw/rtl/scpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo command packet framer package
// Shared word types, command codes, packet constants and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package scpf_pkg;

  // Input word modes.
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Packet constants.
  localparam logic [15:0] CRC_POLY     = 16'h8005;
  localparam logic [7:0]  HDR_SYNC     = 8'hFF;
  localparam logic [7:0]  HDR_FD       = 8'hFD;
  localparam logic [7:0]  HDR_RSVD     = 8'h00;
  localparam logic [7:0]  INSTR_WRITE  = 8'h03;
  localparam logic [7:0]  INSTR_READ   = 8'h02;
  localparam logic [15:0] READ_LENGTH  = 16'h0007;
  localparam logic [7:0]  DEVICE_ID_RST = 8'd1;

  // Body lengths of the command kinds, in bytes.
  localparam logic [3:0] LEN_PAYLOAD = 4'd1;
  localparam logic [3:0] LEN_WRITE   = 4'd10;
  localparam logic [3:0] LEN_READ    = 4'd12;
  localparam logic [3:0] LEN_CRC     = 4'd2;

  // Command queue depth.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [15:0] count;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_end;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_PAYLOAD = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_READ    = 2'd2
  } cmd_kind_e;

  // arg holds the length field for a write start, the data count for a read
  // request, and the data byte (low bits) for a payload byte.
  typedef struct packed {
    cmd_kind_e   kind;
    logic        crc_after;
    logic [15:0] address;
    logic [15:0] arg;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/scpf_front.sv @@
// ----------------------------------------------------------------------------
// Servo command packet framer front end
// Accepts input words, tracks the open write packet and queues commands.
// ----------------------------------------------------------------------------
module scpf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  scpf_pkg::in_word_t in_word_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output scpf_pkg::cmd_t   q_cmd_o
);
  import scpf_pkg::*;

  logic        write_open_q, write_open_d;
  logic [15:0] remaining_q, remaining_d;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    write_open_d = write_open_q;
    remaining_d  = remaining_q;
    q_push_o     = 1'b0;
    q_cmd_o      = '0;
    q_cmd_o.address = in_word_i.address;
    if (accept) begin
      unique case (in_word_i.mode)
        MODE_START: begin
          q_push_o          = 1'b1;
          q_cmd_o.kind      = CMD_WRITE;
          q_cmd_o.arg       = in_word_i.count + 16'd5;
          q_cmd_o.crc_after = (in_word_i.count == 16'd0);
          remaining_d       = in_word_i.count;
          write_open_d      = (in_word_i.count != 16'd0);
        end
        MODE_PAYLOAD: begin
          // A payload byte with no write open is dropped.
          if (write_open_q) begin
            q_push_o          = 1'b1;
            q_cmd_o.kind      = CMD_PAYLOAD;
            q_cmd_o.arg       = {8'h00, in_word_i.data_byte};
            q_cmd_o.crc_after = (remaining_q == 16'd1);
            remaining_d       = remaining_q - 16'd1;
            write_open_d      = (remaining_q != 16'd1);
          end
        end
        MODE_READ: begin
          q_push_o          = 1'b1;
          q_cmd_o.kind      = CMD_READ;
          q_cmd_o.arg       = in_word_i.count;
          q_cmd_o.crc_after = 1'b1;
          remaining_d       = 16'd0;
          write_open_d      = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_open_q <= 1'b0;
      remaining_q  <= 16'd0;
    end else begin
      write_open_q <= write_open_d;
      remaining_q  <= remaining_d;
    end
  end

endmodule

@@ hw/rtl/scpf_queue.sv @@
// ----------------------------------------------------------------------------
// Servo command packet framer command queue
// Short flip-flop FIFO between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module scpf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  scpf_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           head_valid_o,
  output scpf_pkg::cmd_t head_cmd_o,
  input  logic           pop_i
);
  import scpf_pkg::*;

  cmd_t                   slots_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o       = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/scpf_back.sv @@
// ----------------------------------------------------------------------------
// Servo command packet framer serializer
// Turns queued commands into packet bytes, runs the CRC and appends it.
// ----------------------------------------------------------------------------
module scpf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           device_id_i,
  input  logic                 head_valid_i,
  input  scpf_pkg::cmd_t       head_cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output scpf_pkg::out_word_t  out_word_o
);
  import scpf_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, out_d;

  logic [3:0]  body_len, last_idx;
  logic [7:0]  body_byte;
  logic [15:0] crc_base;
  logic        in_body, is_end, fire;

  always_comb begin
    unique case (head_cmd_i.kind)
      CMD_PAYLOAD: body_len = LEN_PAYLOAD;
      CMD_WRITE:   body_len = LEN_WRITE;
      CMD_READ:    body_len = LEN_READ;
      default:     body_len = LEN_PAYLOAD;
    endcase
  end

  assign last_idx = body_len - 4'd1 + (head_cmd_i.crc_after ? LEN_CRC : 4'd0);
  assign in_body  = (idx_q < body_len);
  assign is_end   = !in_body && (idx_q != body_len);

  // Header layout: sync, sync, FD, reserved, id, length lo/hi, instruction,
  // address lo/hi, and for a read the data count lo/hi.
  always_comb begin
    body_byte = HDR_RSVD;
    if (head_cmd_i.kind == CMD_PAYLOAD) begin
      body_byte = head_cmd_i.arg[7:0];
    end else begin
      unique case (idx_q)
        4'd0, 4'd1: body_byte = HDR_SYNC;
        4'd2:       body_byte = HDR_FD;
        4'd3:       body_byte = HDR_RSVD;
        4'd4:       body_byte = device_id_i;
        4'd5:       body_byte = (head_cmd_i.kind == CMD_READ) ? READ_LENGTH[7:0]
                                                              : head_cmd_i.arg[7:0];
        4'd6:       body_byte = (head_cmd_i.kind == CMD_READ) ? READ_LENGTH[15:8]
                                                              : head_cmd_i.arg[15:8];
        4'd7:       body_byte = (head_cmd_i.kind == CMD_READ) ? INSTR_READ : INSTR_WRITE;
        4'd8:       body_byte = head_cmd_i.address[7:0];
        4'd9:       body_byte = head_cmd_i.address[15:8];
        4'd10:      body_byte = head_cmd_i.arg[7:0];
        4'd11:      body_byte = head_cmd_i.arg[15:8];
        default:    body_byte = HDR_RSVD;
      endcase
    end
  end

  // A new header restarts the CRC from zero.
  assign crc_base = (idx_q == 4'd0 && head_cmd_i.kind != CMD_PAYLOAD) ? 16'h0000 : crc_q;
  assign fire     = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = fire && (idx_q == last_idx);

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d = 1'b1;
      idx_d       = pop_o ? 4'd0 : idx_q + 4'd1;
      if (in_body) begin
        out_d.out_byte   = body_byte;
        out_d.packet_end = 1'b0;
        crc_d            = crc16_byte(crc_base, body_byte);
      end else begin
        out_d.out_byte   = is_end ? crc_q[15:8] : crc_q[7:0];
        out_d.packet_end = is_end;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 4'd0;
      crc_q       <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 4'd13)
    else $error("byte index beyond longest packet");

  a_mid_cmd_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 4'd0 |-> head_valid_i)
    else $error("command left the queue before all its bytes were sent");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !pop_o |=> idx_q == $past(idx_q) + 4'd1)
    else $error("byte index did not advance");

  a_end_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && is_end |-> pop_o)
    else $error("packet end byte is not the last byte of its command");

endmodule

@@ hw/rtl/servo_command_packet_framer_crc16_top.sv @@
// ----------------------------------------------------------------------------
// Servo command packet framer with CRC-16
// Frames write and read command packets for a half-duplex servo bus.
// ----------------------------------------------------------------------------
// Each input word is classified by a front end and queued as a command; a
// serializer turns commands into bytes, one byte per cycle while a command
// is queued and the consumer does not stall. A payload word gives one byte
// (three when it closes the packet with the CRC), a write start gives 10
// bytes (12 with a zero count) and a read request gives 14 bytes. The CRC
// is CRC-16 with polynomial 0x8005, initial value zero, no reflection, sent
// low byte first with packet_end set on the high byte. A two-entry command
// queue lets the input side keep accepting words while the serializer
// drains a header, and the output register holds a byte while the consumer
// stalls. The device id register resets to 1; the user must write it with
// cfg_we_i only while the block is idle, which the block does not enforce.
module servo_command_packet_framer_crc16_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  scpf_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output scpf_pkg::out_word_t out_word_o
);
  import scpf_pkg::*;

  logic [7:0] device_id_q;
  logic       q_full, q_push, head_valid, pop;
  cmd_t       q_cmd, head_cmd;

  // Only the serializer reads the device id; the user must change it only when
  // the block is idle (not enforced here), so no copy travels with commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= DEVICE_ID_RST;
    end else if (cfg_we_i) begin
      device_id_q <= cfg_wdata_i;
    end
  end

  scpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd)
  );

  scpf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_cmd_i   (q_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  scpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .device_id_i  (device_id_q),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule
